// ===== sv/htcb_pkg.sv =====
// ----------------------------------------------------------------------------
// htcb_pkg
// shared types and constants of the huffman tree code builder
// ----------------------------------------------------------------------------
package htcb_pkg;

   localparam int VOCAB_WORDS_DEF = 4096;
   localparam int MAX_CODE_DEF    = 40;
   localparam int COUNT_W         = 56;
   localparam int IN_COUNT_W      = 40;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOTREE = 2'd1;
   localparam logic [1:0] ST_NOCODE = 2'd2;
   localparam logic [1:0] ST_TRUNC  = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [39:0] word_count;
      logic        last_word;
      logic [11:0] word_index;
   } req_type;

   typedef struct packed {
      logic        code_bit;
      logic [11:0] node_index;
      logic [5:0]  depth_pos;
      logic        is_last;
      logic [5:0]  code_len;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ===== sv/htcb_front.sv =====
// ----------------------------------------------------------------------------
// htcb_front
// accepts command items and queues them for the tree engine
// ----------------------------------------------------------------------------
module htcb_front
   import htcb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req,
   output logic    busy,
   output logic    q_valid,
   output req_type q_item,
   input  logic    q_pop
);

   // two-entry queue
   req_type    mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
      rd_in  = rd_ff ^ (q_pop && q_valid);
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) mem_ff[wr_ff] <= req;
   end

endmodule

// ===== sv/htcb_engine.sv =====
// ----------------------------------------------------------------------------
// htcb_engine
// stores counts, builds the tree by two-queue merge and walks codes
// ----------------------------------------------------------------------------
module htcb_engine
   import htcb_pkg::*;
#(
   parameter int VOCAB_WORDS = VOCAB_WORDS_DEF,
   parameter int MAX_CODE    = MAX_CODE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  req_type q_item,
   output logic    q_pop,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   localparam int SLOTS = 2 * VOCAB_WORDS;
   localparam int AW    = $clog2(SLOTS);
   localparam int WW    = $clog2(VOCAB_WORDS + 1);
   localparam int MW    = AW + 1;
   localparam int DW    = $clog2(MAX_CODE + 1);
   localparam int PW    = (MAX_CODE > 1) ? $clog2(MAX_CODE) : 1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_CLR    = 12'b000000000010,
      S_RDA    = 12'b000000000100,
      S_CMPA   = 12'b000000001000,
      S_RDB    = 12'b000000010000,
      S_CMPB   = 12'b000000100000,
      S_SUM    = 12'b000001000000,
      S_WALK   = 12'b000010000000,
      S_WWAIT  = 12'b000100000000,
      S_FILL   = 12'b001000000000,
      S_FWAIT  = 12'b010000000000,
      S_EMIT   = 12'b100000000000
   } state_type;

   logic [COUNT_W-1:0] cnt_mem [SLOTS];
   logic [AW:0]        par_mem [SLOTS];
   logic               br_mem  [SLOTS];
   logic               pb_mem  [MAX_CODE];
   logic [11:0]        pn_mem  [MAX_CODE];

   state_type state_ff, state_in;
   logic [WW-1:0] words_ff;
   logic          ready_ff;
   logic [AW:0]   lh_ff;       // leaves not yet merged
   logic [MW:0]   mh_ff;       // merged queue head
   logic [AW:0]   made_ff;
   logic [AW:0]   clr_ff;
   logic [AW-1:0] a_ff, b_ff;
   logic [COUNT_W-1:0] ca_ff, cb_ff, lc_ff, mc_ff;
   logic [AW:0]   node_ff;
   logic [AW:0]   pd_ff;
   logic          bd_ff;
   logic [AW:0]   depth_ff;
   logic [AW:0]   step_ff;
   logic [DW-1:0] k_ff, emit_ff;
   logic [1:0]    st_ff;
   logic [AW:0]   wword_ff;

   // read ports
   logic [AW-1:0] rl_addr, rm_addr, rp_addr;
   logic [COUNT_W-1:0] rl_q, rm_q;

   logic [AW:0]  vext, root;
   logic         leaf_ok, take_leaf;
   logic [AW-1:0] pick;
   logic [COUNT_W:0] sum;

   assign vext = (AW+1)'(words_ff);
   assign root = (AW+1)'(2 * words_ff) - (AW+1)'(2);

   always_ff @(posedge clock) begin
      lc_ff <= cnt_mem[rl_addr];
      mc_ff <= cnt_mem[rm_addr];
      pd_ff <= par_mem[rp_addr];
      bd_ff <= br_mem[rp_addr];
   end
   assign rl_q = lc_ff;
   assign rm_q = mc_ff;

   always_comb begin
      rl_addr = AW'(lh_ff - (AW+1)'(1));
      rm_addr = mh_ff[AW-1:0];
      rp_addr = node_ff[AW-1:0];
   end

   assign leaf_ok   = (lh_ff != '0) &&
                      ((mh_ff >= (MW+1)'(made_ff)) || (rl_q < rm_q));
   assign take_leaf = leaf_ok;
   assign pick      = take_leaf ? AW'(lh_ff - (AW+1)'(1)) : mh_ff[AW-1:0];
   assign sum       = {1'b0, ca_ff} + {1'b0, cb_ff};

   logic is_load, is_q;
   assign is_load = q_valid && q_item.cmd == CMD_LOAD;
   assign is_q    = q_valid && q_item.cmd == CMD_QUERY;
   assign q_pop   = (state_ff == S_IDLE) && q_valid;

   logic [AW:0] wnew;
   logic [WW-1:0] lw_base, lw_next;
   logic          lw_room;
   always_comb begin
      // a load after a build starts a new vocabulary
      lw_base = ready_ff ? '0 : words_ff;
      lw_room = (lw_base < WW'(VOCAB_WORDS));
      lw_next = lw_room ? lw_base + WW'(1) : lw_base;
      wnew    = (AW+1)'(q_item.word_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         words_ff   <= '0;
         ready_ff   <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (is_load) begin
               if (lw_room) cnt_mem[AW'(lw_base)] <= COUNT_W'(q_item.word_count);
               words_ff <= lw_next;
               ready_ff <= 1'b0;
               if (q_item.last_word && lw_next != '0) begin
                  clr_ff   <= '0;
                  state_ff <= S_CLR;
               end
            end else if (is_q) begin
               wword_ff <= wnew;
               if (!ready_ff || wnew >= vext) begin
                  rsp <= '{1'b0, 12'd0, 6'd0, 1'b1, 6'd0, ST_NOTREE};
                  rsp_strobe <= 1'b1;
               end else if (words_ff < WW'(2)) begin
                  rsp <= '{1'b0, 12'd0, 6'd0, 1'b1, 6'd0, ST_NOCODE};
                  rsp_strobe <= 1'b1;
               end else begin
                  node_ff  <= wnew;
                  depth_ff <= '0;
                  state_ff <= S_WALK;
               end
            end
            S_CLR: begin
               br_mem[clr_ff[AW-1:0]] <= 1'b0;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AW+1)'(SLOTS - 1)) begin
                  lh_ff   <= vext;
                  mh_ff   <= (MW+1)'(vext);
                  made_ff <= vext;
                  state_ff <= (words_ff < WW'(2)) ? S_IDLE : S_RDA;
                  ready_ff <= (words_ff < WW'(2));
               end
            end
            S_RDA:  state_ff <= S_CMPA;
            S_CMPA: begin
               a_ff <= pick;
               ca_ff <= take_leaf ? rl_q : rm_q;
               if (take_leaf) lh_ff <= lh_ff - 1'b1;
               else mh_ff <= mh_ff + 1'b1;
               state_ff <= S_RDB;
            end
            S_RDB:  state_ff <= S_CMPB;
            S_CMPB: begin
               b_ff <= pick;
               cb_ff <= take_leaf ? rl_q : rm_q;
               par_mem[a_ff] <= made_ff;
               if (take_leaf) lh_ff <= lh_ff - 1'b1;
               else mh_ff <= mh_ff + 1'b1;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               cnt_mem[made_ff[AW-1:0]] <= sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
               par_mem[b_ff] <= made_ff;
               br_mem[b_ff]  <= 1'b1;
               made_ff <= made_ff + 1'b1;
               if (made_ff + 1'b1 == root + 1'b1) begin
                  ready_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else state_ff <= S_RDA;
            end
            S_WALK: state_ff <= S_WWAIT;
            S_WWAIT: begin
               if (node_ff == root) begin
                  emit_ff <= (depth_ff < (AW+1)'(MAX_CODE)) ? DW'(depth_ff) : DW'(MAX_CODE);
                  st_ff <= (depth_ff > (AW+1)'(MAX_CODE)) ? ST_TRUNC : ST_OK;
                  node_ff <= wword_ff;
                  step_ff <= '0;
                  state_ff <= S_FILL;
               end else begin
                  node_ff <= pd_ff;
                  depth_ff <= depth_ff + 1'b1;
                  state_ff <= S_WALK;
               end
            end
            S_FILL: state_ff <= S_FWAIT;
            S_FWAIT: begin
               if (step_ff + (AW+1)'(MAX_CODE) >= depth_ff) begin
                  pb_mem[PW'(depth_ff - step_ff - 1'b1)] <= bd_ff;
                  pn_mem[PW'(depth_ff - step_ff - 1'b1)] <= 12'(pd_ff - vext);
               end
               node_ff <= pd_ff;
               step_ff <= step_ff + 1'b1;
               if (step_ff + 1'b1 == depth_ff) begin
                  k_ff <= '0;
                  state_ff <= S_EMIT;
               end else state_ff <= S_FILL;
            end
            S_EMIT: begin
               rsp <= '{pb_mem[PW'(k_ff)], pn_mem[PW'(k_ff)], 6'(k_ff),
                        (k_ff + 1'b1 == emit_ff), 6'(emit_ff), st_ff};
               rsp_strobe <= 1'b1;
               k_ff <= k_ff + 1'b1;
               if (k_ff + 1'b1 == emit_ff) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== sv/huffman_tree_code_builder.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_code_builder
// loads sorted counts, builds a huffman tree, answers code queries
// ----------------------------------------------------------------------------
// a load takes effect once the engine pops it from the queue; a build clears
//   2*VOCAB_WORDS branch bits, one per cycle, then merges two nodes at a time
// query: the parent links are walked twice, then one result item per cycle
// throughput: busy holds start off while the two-item queue is full
// the receiver cannot stall results; reset is synchronous and clears queue and
//   control, memories hold until written
module huffman_tree_code_builder
   import htcb_pkg::*;
#(
   parameter int VOCAB_WORDS = VOCAB_WORDS_DEF,
   parameter int MAX_CODE    = MAX_CODE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   logic    q_valid, q_pop;
   req_type q_item;

   htcb_front u_front (
      .clock, .reset, .start, .req(req_item), .busy,
      .q_valid, .q_item, .q_pop
   );

   htcb_engine #(.VOCAB_WORDS(VOCAB_WORDS), .MAX_CODE(MAX_CODE)) u_engine (
      .clock, .reset, .q_valid, .q_item, .q_pop,
      .rsp_strobe, .rsp(rsp_item)
   );

endmodule

// ===== sv/htcb_checker.sv =====
// ----------------------------------------------------------------------------
// htcb_checker
// port-level checks of the code builder
// ----------------------------------------------------------------------------
module htcb_checker
   import htcb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({busy, rsp_strobe})) else $error("unknown handshake");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.status == ST_NOTREE || rsp_item.status == ST_NOCODE)
      |-> rsp_item.is_last && rsp_item.code_len == 6'd0) else $error("bad err item");

   a_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.depth_pos < rsp_item.code_len ||
      rsp_item.code_len == 6'd0) else $error("depth beyond length");

   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.is_last |=> rsp_strobe &&
      rsp_item.depth_pos == $past(rsp_item.depth_pos) + 6'd1) else $error("gap in code");

endmodule

bind huffman_tree_code_builder htcb_checker u_chk (
   .clock, .reset, .busy, .rsp_strobe, .rsp_item
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the huffman code builder: sorted count sets are loaded, each set
// is built into a tree, and word codes are queried; a local copy of the
// two-queue build predicts every code bit, node and status, and each result
// item is compared in order against the predicted stream
// ----------------------------------------------------------------------------
module tb_top;
   import htcb_pkg::*;

   localparam int VOCAB = VOCAB_WORDS_DEF;
   localparam int MAXC  = MAX_CODE_DEF;
   localparam int SLOTS = 2 * VOCAB;
   localparam logic [55:0] COUNT_SAT = {56{1'b1}};

   typedef struct {
      req_type item;
      bit      drain;
   } pending_type;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_item;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   huffman_tree_code_builder dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   pending_type pending_items[$];
   rsp_type     code_bits_due[$];
   int          fail_count = 0;
   int          gap_left   = 0;
   bit          quiet_mode = 0;

   // predictor state
   logic [55:0] node_cnt[SLOTS];
   int unsigned node_parent[SLOTS];
   bit          node_branch[SLOTS];
   int unsigned word_total  = 0;
   bit          have_tree   = 0;
   int unsigned leaf_ptr;
   int unsigned merge_ptr;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned pick_smaller(int unsigned made);
      int unsigned pick;
      if (leaf_ptr > 0 && (merge_ptr >= made ||
            node_cnt[leaf_ptr - 1] < node_cnt[merge_ptr % SLOTS])) begin
         leaf_ptr--;
         pick = leaf_ptr;
      end else begin
         pick = merge_ptr % SLOTS;
         merge_ptr++;
      end
      return pick;
   endfunction

   function automatic void build_huffman();
      int unsigned a, b, made;
      logic [56:0] sum;
      foreach (node_branch[i]) node_branch[i] = 0;
      leaf_ptr  = word_total;
      merge_ptr = word_total;
      for (int unsigned nn = 0; nn + 1 < word_total; nn++) begin
         made = word_total + nn;
         a = pick_smaller(made);
         b = pick_smaller(made);
         sum = node_cnt[a] + node_cnt[b];
         node_cnt[made % SLOTS] = (sum > COUNT_SAT) ? COUNT_SAT : sum[55:0];
         node_parent[a] = made;
         node_parent[b] = made;
         node_branch[b] = 1;
      end
      have_tree = 1;
   endfunction

   function automatic rsp_type mk_rsp(bit cb, int unsigned nd, int unsigned pos, bit lst,
                                      int unsigned len, logic [1:0] st);
      rsp_type r;
      r.code_bit   = cb;
      r.node_index = nd[11:0];
      r.depth_pos  = pos[5:0];
      r.is_last    = lst;
      r.code_len   = len[5:0];
      r.status     = st;
      return r;
   endfunction

   // apply one accepted item and queue the code bits it produces
   function automatic void predict_code(req_type it);
      int unsigned w, root, node, depth, emit, skip, p, d;
      logic [1:0]  st;
      bit          bits[MAXC];
      int unsigned nodes[MAXC];
      if (it.cmd == CMD_LOAD) begin
         if (have_tree) begin
            have_tree  = 0;
            word_total = 0;
         end
         if (word_total < VOCAB) begin
            node_cnt[word_total] = {16'd0, it.word_count};
            word_total++;
         end
         if (it.last_word && word_total > 0) build_huffman();
         return;
      end
      w = it.word_index;
      if (!have_tree || w >= word_total) begin
         code_bits_due.push_back(mk_rsp(0, 0, 0, 1, 0, ST_NOTREE));
         return;
      end
      if (word_total < 2) begin
         code_bits_due.push_back(mk_rsp(0, 0, 0, 1, 0, ST_NOCODE));
         return;
      end
      root  = 2 * word_total - 2;
      node  = w;
      depth = 0;
      while (node != root && depth < 2 * word_total) begin
         node = node_parent[node % SLOTS];
         depth++;
      end
      emit = (depth < MAXC) ? depth : MAXC;
      skip = depth - emit;
      st   = (depth > MAXC) ? ST_TRUNC : ST_OK;
      node = w;
      for (int unsigned s = 0; s < depth; s++) begin
         p = node_parent[node % SLOTS];
         if (s >= skip) begin
            d = depth - 1 - s;
            bits[d]  = node_branch[node % SLOTS];
            nodes[d] = (p - word_total) & 12'hFFF;
         end
         node = p;
      end
      for (int unsigned k = 0; k < emit; k++)
         code_bits_due.push_back(mk_rsp(bits[k], nodes[k], k, k + 1 == emit, emit, st));
   endfunction

   // driver
   always @(posedge clock) begin
      pending_type nx;
      if (reset) begin
         start    <= 0;
         req_item <= '0;
      end else begin
         if (start && !busy) predict_code(req_item);
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start    <= 0;
            end else if (pending_items.size() > 0 &&
                  !(pending_items[0].drain && (start || code_bits_due.size() > 0))) begin
               nx = pending_items.pop_front();
               start    <= 1;
               req_item <= nx.item;
               if ($urandom_range(0, 15) == 0) quiet_mode = !quiet_mode;
               gap_left <= quiet_mode ? 0 : $urandom_range(0, 18);
            end else begin
               start <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (code_bits_due.size() == 0) begin
            $error("unexpected result item %p", rsp_item);
            fail_count++;
         end else begin
            want = code_bits_due.pop_front();
            if (rsp_item.code_bit !== want.code_bit) begin
               $error("code_bit exp %0d got %0d", want.code_bit, rsp_item.code_bit);
               fail_count++;
            end
            if (rsp_item.node_index !== want.node_index) begin
               $error("node_index exp %0d got %0d", want.node_index, rsp_item.node_index);
               fail_count++;
            end
            if (rsp_item.depth_pos !== want.depth_pos) begin
               $error("depth_pos exp %0d got %0d", want.depth_pos, rsp_item.depth_pos);
               fail_count++;
            end
            if (rsp_item.is_last !== want.is_last) begin
               $error("is_last exp %0d got %0d", want.is_last, rsp_item.is_last);
               fail_count++;
            end
            if (rsp_item.code_len !== want.code_len) begin
               $error("code_len exp %0d got %0d", want.code_len, rsp_item.code_len);
               fail_count++;
            end
            if (rsp_item.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_item.status);
               fail_count++;
            end
         end
      end
   end

   task automatic add_item(bit cmd, logic [39:0] cnt, bit lst, logic [11:0] idx,
                           bit drain = 0);
      pending_type p;
      p.item.cmd        = cmd;
      p.item.word_count = cnt;
      p.item.last_word  = lst;
      p.item.word_index = idx;
      p.drain           = drain;
      pending_items.push_back(p);
   endtask

   function automatic logic [39:0] rand_count();
      logic [39:0] c;
      c = 40'({$urandom, $urandom});
      return c >> $urandom_range(0, 39);
   endfunction

   // one sorted set of counts, last one flagged
   task automatic add_count_set(int n);
      logic [39:0] cs[$];
      for (int i = 0; i < n; i++) cs.push_back(rand_count());
      cs.rsort();
      for (int i = 0; i < n; i++)
         add_item(CMD_LOAD, cs[i], i == n - 1, 12'($urandom));
   endtask

   initial begin
      int sent;
      int n;
      reset = 1;

      // directed: no tree, one word, two extremes, unfinished load
      add_item(CMD_QUERY, '1, 1'b1, 12'd0);
      add_item(CMD_LOAD, 40'd77, 1'b1, 12'hFFF);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'd0);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'd1);
      add_item(CMD_LOAD, 40'hFF_FFFF_FFFF, 1'b0, 12'd0);
      add_item(CMD_LOAD, 40'd0, 1'b1, 12'd0);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'd0);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'd1);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'hFFF);
      add_item(CMD_LOAD, 40'd5, 1'b0, 12'd0);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'd0, 1);
      // all-zero counts chain into a deep tree, codes past the limit
      for (int i = 0; i < 50; i++) add_item(CMD_LOAD, 40'd0, i == 49, 12'd0);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'd49);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'd48);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'd10);
      add_item(CMD_QUERY, 40'd0, 1'b0, 12'd0);

      // random sets, mostly well formed
      sent = 0;
      while (sent < 85) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         if ($urandom_range(0, 5) == 0) begin
            // broken set: queries while loading
            add_item(CMD_LOAD, rand_count(), 1'b0, 12'($urandom));
            add_item(CMD_QUERY, 40'($urandom), 1'($urandom), 12'($urandom));
            sent += 2;
         end
         add_count_set(n);
         sent += n;
         for (int q = $urandom_range(2, 8); q > 0; q--) begin
            add_item(CMD_QUERY, rand_count(), 1'($urandom), ($urandom_range(0, 7) == 0) ?
                     12'($urandom) : 12'($urandom_range(0, n - 1)),
                     $urandom_range(0, 9) == 0);
            sent++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 0;
      wait (pending_items.size() == 0 && !start);
      wait (code_bits_due.size() == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0 && code_bits_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(12 * 10_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
